// ----- hw/rtl/lhfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lhfr_pkg: shared types and constants of the link frame receiver
// Word formats, result kinds, link byte codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lhfr_pkg;

  // link byte codes
  localparam logic [7:0] ReqSingle    = 8'hA5;
  localparam logic [7:0] ReqMulti     = 8'hA6;
  localparam logic [7:0] ReplyConfirm = 8'h5A;
  localparam logic [7:0] ReplyDeny    = 8'h66;
  localparam logic [7:0] FrameStart   = 8'hC3;
  localparam logic [7:0] PingByte     = 8'h15;

  // register reset values
  localparam logic [15:0] TimeoutReset = 16'd5000;

  // input word action codes
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSendingBusy = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOverByte    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout     = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // result kinds
  typedef enum logic [2:0] {
    KindSend    = 3'd0,
    KindCmd     = 3'd1,
    KindPayload = 3'd2,
    KindAccept  = 3'd3,
    KindReject  = 3'd4
  } kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // one queue entry: the one or two results of an input word
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lhfr_front.sv -----
// ----------------------------------------------------------------------------
// lhfr_front: input side of the link frame receiver
// Accepts words, runs the session/frame parser and pushes result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lhfr_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire lhfr_pkg::in_t          in_data_i,
  input  wire                         cfg_we_i,
  input  wire [lhfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [lhfr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                         q_full_i,
  output logic                        push_o,
  output lhfr_pkg::entry_t            entry_o
);
  import lhfr_pkg::*;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhStart   = 3'd1,
    PhCmd     = 3'd2,
    PhSize    = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        multi_q, multi_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  check_q, check_d;
  logic [15:0] timer_q, timer_d, timer_inc;
  logic        busy_q;
  logic [7:0]  over_q;
  logic [15:0] tmo_q;

  logic        accept, take;
  logic [7:0]  b;
  logic [1:0]  cnt;
  out_t        r0, r1;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // wait timer: saturating tick count, a timeout stands for a zero byte
  always_comb begin
    timer_inc = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;
    take      = 1'b0;
    b         = 8'h00;
    timer_d   = timer_q;
    if (in_data_i.action == ActByte) begin
      take    = 1'b1;
      b       = in_data_i.rx_byte;
      timer_d = '0;
    end else if (timer_inc >= tmo_q) begin
      take    = 1'b1;
      timer_d = '0;
    end else begin
      timer_d = timer_inc;
    end
  end

  // byte parser
  always_comb begin
    phase_d = phase_q;
    multi_d = multi_q;
    left_d  = left_q;
    check_d = check_q;
    cnt     = 2'd0;
    r0      = '{out_kind: KindSend, out_byte: 8'h00, out_last: 1'b0};
    r1      = '{out_kind: KindSend, out_byte: over_q, out_last: 1'b1};
    case (phase_q)
      PhStart: begin
        if (b == FrameStart) begin
          phase_d = PhCmd;
        end else begin
          // missing start byte: frame starts with command zero
          check_d     = FrameStart;
          cnt         = 2'd1;
          r0.out_kind = KindCmd;
          phase_d     = PhSize;
        end
      end
      PhCmd: begin
        check_d     = FrameStart ^ b;
        cnt         = 2'd1;
        r0.out_kind = KindCmd;
        r0.out_byte = b;
        phase_d     = PhSize;
      end
      PhSize: begin
        check_d = check_q ^ b;
        left_d  = b;
        phase_d = (b == 8'h00) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        check_d     = check_q ^ b;
        cnt         = 2'd1;
        r0.out_kind = KindPayload;
        r0.out_byte = b;
        left_d      = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        if (b == check_q) begin
          r0.out_kind = KindAccept;
          if (multi_q) begin
            cnt     = 2'd1;
            phase_d = PhStart;
          end else begin
            cnt     = 2'd2;
            phase_d = PhIdle;
          end
        end else begin
          r0.out_kind = KindReject;
          cnt         = 2'd2;
          phase_d     = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
        if (b == ReqSingle || b == ReqMulti) begin
          cnt = 2'd1;
          if (busy_q) begin
            r0.out_byte = ReplyDeny;
          end else begin
            r0.out_byte = ReplyConfirm;
            multi_d     = (b == ReqMulti);
            left_d      = 8'h00;
            check_d     = 8'h00;
            phase_d     = PhStart;
          end
        end else if (b == PingByte) begin
          cnt         = 2'd1;
          r0.out_byte = ReplyConfirm;
        end
      end
    endcase
    r0.out_last = (cnt == 2'd1);
  end

  assign push_o  = accept && take && (cnt != 2'd0);
  assign entry_o = '{two: (cnt == 2'd2), r0: r0, r1: r1};

  // parser state, timer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      multi_q <= 1'b0;
      left_q  <= '0;
      check_q <= '0;
      timer_q <= '0;
      busy_q  <= 1'b0;
      over_q  <= '0;
      tmo_q   <= TimeoutReset;
    end else begin
      if (accept) begin
        timer_q <= timer_d;
        if (take) begin
          phase_q <= phase_d;
          multi_q <= multi_d;
          left_q  <= left_d;
          check_q <= check_d;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSendingBusy: busy_q <= cfg_data_i[0];
          CfgOverByte:    over_q <= cfg_data_i[7:0];
          CfgTimeout:     tmo_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lhfr_queue.sv -----
// ----------------------------------------------------------------------------
// lhfr_queue: result entry queue of the link frame receiver
// Short FIFO between parser and output side; head is read in place.
// ----------------------------------------------------------------------------
`default_nettype none

module lhfr_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire lhfr_pkg::entry_t  entry_i,
  input  wire                    pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output lhfr_pkg::entry_t       head_o
);
  import lhfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("entry pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("entry popped from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count out of range");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (head_o.two ? head_o.r1.out_last : head_o.r0.out_last))
    else $error("queue head lacks last mark");

endmodule

`default_nettype wire

// ----- hw/rtl/lhfr_back.sv -----
// ----------------------------------------------------------------------------
// lhfr_back: output side of the link frame receiver
// Sends the one or two results of each queue entry as output words.
// ----------------------------------------------------------------------------
`default_nettype none

module lhfr_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    empty_i,
  input  wire lhfr_pkg::entry_t  head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output lhfr_pkg::out_t         out_data_o
);
  import lhfr_pkg::*;

  logic sub_q;
  logic fire;

  assign out_valid_o = !empty_i;
  assign out_data_o  = sub_q ? head_i.r1 : head_i.r0;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && (sub_q || !head_i.two);

  // second-result select within the head entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (fire) begin
      sub_q <= !pop_o;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/link_handshake_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// link_handshake_frame_receiver: receive side of a serial radio link
// Parses request, ping and frame bytes and emits replies and frame data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one word per cycle,
//   a received byte or one time tick, while the queue is not full. Each word
//   gives zero, one or two result words on the output channel (out_valid_o/
//   out_ready_i/out_data_o), the final one of a word carrying out_last.
//   A result is written into the queue when its input word is accepted and
//   is shown on the output from the queue head. Throughput: one input word
//   per cycle while the queue is not full; the output side drains one result
//   a cycle while out_ready_i is high, sending a two-result word as two words.
//   A QDepth-entry queue sits between parser and output side; when the
//   receiver stalls the queue fills and in_ready_o drops only when it is full.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 sending busy, 1 over byte, 2 timeout ticks); write only while idle.
//   Reset: parser idle, queue empty, sending busy 0, over byte 0,
//   timeout 5000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module link_handshake_frame_receiver #(
  parameter int unsigned QDepth = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire lhfr_pkg::in_t           in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output lhfr_pkg::out_t               out_data_o,
  input  wire                          cfg_we_i,
  input  wire [lhfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [lhfr_pkg::CfgDataW-1:0] cfg_data_i
);
  import lhfr_pkg::*;

  logic   q_full, q_empty, push, pop;
  entry_t entry, head;

  lhfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  lhfr_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  lhfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb_link_handshake_frame_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_handshake_frame_receiver: self-checking bench for the link receiver
// Feeds received bytes and time ticks through the input channel, predicts the
// replies, delivered frame words and verdicts in a cycle-free model of the
// parser, and compares every result word in order. Both channels idle and
// stall at random. Register settings change between phases while idle.
// ----------------------------------------------------------------------------

module tb_link_handshake_frame_receiver;
  import lhfr_pkg::*;

  localparam int unsigned ClkHalf      = 10;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned MaxIdle      = 12;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RandWords    = 550;
  localparam int unsigned PhaseWords   = 70;
  localparam int unsigned MaxPrinted   = 40;

  // parser phases of the prediction
  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhStart   = 3'd1,
    PhCmd     = 3'd2,
    PhSize    = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } link_phase_e;

  // DUT signals
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // stimulus and expected results
  in_t  pending_words_q [$];
  out_t expected_results_q [$];

  // predicted register copies
  logic        cfg_busy    = 1'b0;
  logic [7:0]  cfg_over    = 8'h00;
  logic [15:0] cfg_timeout = TimeoutReset;

  // predicted parser state
  link_phase_e link_phase  = PhIdle;
  logic        multi_open  = 1'b0;
  logic [7:0]  left_count  = 8'h00;
  logic [7:0]  frame_xor   = 8'h00;
  logic [15:0] quiet_ticks = 16'h0000;

  // run bookkeeping
  int unsigned error_count    = 0;
  int unsigned words_queued   = 0;
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned sessions_built = 0;
  int unsigned settings_count = 0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;
  int unsigned quiet_cycles   = 0;

  link_handshake_frame_receiver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic out_t make_result(input kind_e kind, input logic [7:0] b);
    out_t r;
    r.out_kind = kind;
    r.out_byte = b;
    r.out_last = 1'b0;
    return r;
  endfunction

  // one byte through the parser; queues the results it causes
  task automatic parse_link_byte(input logic [7:0] b);
    out_t res [2];
    int   n;
    n = 0;
    case (link_phase)
      PhStart: begin
        if (b == FrameStart) begin
          link_phase = PhCmd;
        end else begin
          // bad start byte doubles as start plus a zero command
          frame_xor = FrameStart;
          res[n] = make_result(KindCmd, 8'h00);
          n++;
          link_phase = PhSize;
        end
      end
      PhCmd: begin
        frame_xor = FrameStart ^ b;
        res[n] = make_result(KindCmd, b);
        n++;
        link_phase = PhSize;
      end
      PhSize: begin
        frame_xor = frame_xor ^ b;
        left_count = b;
        link_phase = (b == 8'h00) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        frame_xor = frame_xor ^ b;
        res[n] = make_result(KindPayload, b);
        n++;
        left_count = left_count - 8'd1;
        if (left_count == 8'h00) link_phase = PhCheck;
      end
      PhCheck: begin
        if (b == frame_xor) begin
          res[n] = make_result(KindAccept, 8'h00);
          n++;
          if (multi_open) begin
            link_phase = PhStart;
          end else begin
            res[n] = make_result(KindSend, cfg_over);
            n++;
            link_phase = PhIdle;
          end
        end else begin
          res[n] = make_result(KindReject, 8'h00);
          n++;
          res[n] = make_result(KindSend, cfg_over);
          n++;
          link_phase = PhIdle;
        end
      end
      default: begin
        link_phase = PhIdle;
        if (b == ReqSingle || b == ReqMulti) begin
          if (cfg_busy) begin
            res[n] = make_result(KindSend, ReplyDeny);
            n++;
          end else begin
            res[n] = make_result(KindSend, ReplyConfirm);
            n++;
            multi_open = (b == ReqMulti);
            left_count = 8'h00;
            frame_xor  = 8'h00;
            link_phase = PhStart;
          end
        end else if (b == PingByte) begin
          res[n] = make_result(KindSend, ReplyConfirm);
          n++;
        end
      end
    endcase
    if (n > 0) res[n-1].out_last = 1'b1;
    for (int i = 0; i < n; i++) expected_results_q.push_back(res[i]);
  endtask

  // one accepted word: a byte clears the wait timer, a tick may time out
  task automatic parse_link_word(input in_t w);
    if (w.action == ActByte) begin
      quiet_ticks = 16'h0000;
      parse_link_byte(w.rx_byte);
    end else begin
      if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
      if (quiet_ticks >= cfg_timeout) begin
        quiet_ticks = 16'h0000;
        parse_link_byte(8'h00);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected: kind %0d byte %02h last %0b",
                                got.out_kind, got.out_byte, got.out_last));
      return;
    end
    want = expected_results_q.pop_front();
    if (got.out_kind !== want.out_kind)
      report_mismatch($sformatf("result %0d out_kind %0d, expected %0d",
                                results_seen, got.out_kind, want.out_kind));
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                results_seen, got.out_byte, want.out_byte));
    if (got.out_last !== want.out_last)
      report_mismatch($sformatf("result %0d out_last %0b, expected %0b",
                                results_seen, got.out_last, want.out_last));
  endtask

  function automatic int unsigned draw_idle(input bit burst);
    return burst ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  // --------------------------------------------------------------------------
  // input driver: pops pending words, idles a random count after each
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_link_word(in_data_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (pending_words_q.size() != 0) begin
          in_data_i  <= pending_words_q.pop_front();
          in_valid_i <= 1'b1;
          in_gap     <= draw_idle(tx_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor: checks each word, stalls a random count after each
  // --------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        results_seen++;
        stall = draw_idle(rx_burst);
        out_stall   <= stall;
        out_ready_i <= (stall == 0);
      end else if (out_stall != 0) begin
        out_stall   <= out_stall - 1;
        out_ready_i <= (out_stall == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog: cycles in a row with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    in_t w;
    w.action  = ActByte;
    w.rx_byte = b;
    pending_words_q.push_back(w);
    words_queued++;
  endtask

  // rx_byte is don't-care on a tick, so keep it moving
  task automatic push_tick();
    in_t w;
    w.action  = ActTick;
    w.rx_byte = 8'($urandom_range(0, 255));
    pending_words_q.push_back(w);
    words_queued++;
  endtask

  // one frame with random content; a stray tick now and then
  task automatic push_frame(input bit good_start, input bit good_check,
                            input int unsigned size);
    logic [7:0] frame_q [$];
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] p;
    cmd = good_start ? 8'($urandom_range(0, 255)) : 8'h00;
    if (good_start) begin
      frame_q.push_back(FrameStart);
      frame_q.push_back(cmd);
    end else begin
      p = 8'($urandom_range(0, 255));
      if (p == FrameStart) p = ~p;
      frame_q.push_back(p);
    end
    sum = FrameStart ^ cmd ^ size[7:0];
    frame_q.push_back(size[7:0]);
    for (int unsigned i = 0; i < size; i++) begin
      p = 8'($urandom_range(0, 255));
      sum = sum ^ p;
      frame_q.push_back(p);
    end
    if (!good_check) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    frame_q.push_back(sum);
    foreach (frame_q[i]) begin
      push_byte(frame_q[i]);
      if ($urandom_range(0, 39) == 0) push_tick();
    end
  endtask

  // request, frames and, for a multi session, mostly a closing bad frame
  task automatic push_session();
    bit          multi;
    int unsigned frames;
    int unsigned size;
    multi  = 1'($urandom_range(0, 1));
    frames = multi ? $urandom_range(1, 3) : 1;
    push_byte(multi ? ReqMulti : ReqSingle);
    for (int unsigned f = 0; f < frames; f++) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      push_frame($urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0, size);
    end
    if (multi && $urandom_range(0, 7) != 0) push_frame(1'b1, 1'b0, $urandom_range(0, 2));
    sessions_built++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words_q.size() != 0 || in_valid_i || expected_results_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgSendingBusy: cfg_busy    = data[0];
      CfgOverByte:    cfg_over    = data[7:0];
      CfgTimeout:     cfg_timeout = data[15:0];
      default: ;
    endcase
  endtask

  // new register setting once the block has gone quiet
  task automatic apply_settings(input logic busy, input logic [7:0] over,
                                input logic [15:0] timeout);
    wait_drained();
    write_reg(CfgSendingBusy, {15'd0, busy});
    write_reg(CfgOverByte, {8'd0, over});
    write_reg(CfgTimeout, timeout);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_start;
    int unsigned phase_start;
    logic [15:0] timeout;
    logic [7:0]  over;
    int unsigned pick;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings; ping, idle junk, one good single frame,
    // bad start with size 0 and bad checksum, request codes as frame data
    push_byte(PingByte);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_tick();
    push_byte(ReqSingle);
    push_byte(FrameStart);
    push_byte(8'hFF);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(FrameStart ^ 8'hFF ^ 8'h02 ^ 8'h00 ^ 8'hFF);
    push_byte(ReqMulti);
    push_byte(8'h12);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(ReqMulti);
    push_byte(FrameStart);
    push_byte(ReqSingle);
    push_byte(8'h01);
    push_byte(ReqMulti);
    push_byte(FrameStart ^ ReqSingle ^ 8'h01 ^ ReqMulti);

    // one-tick timeout closes the open multi session, then busy denies
    apply_settings(1'b1, 8'hFF, 16'd1);
    push_tick();
    push_tick();
    push_tick();
    push_byte(ReqMulti);
    push_byte(ReqSingle);

    // zero timeout: every tick times out, no effect while idle
    apply_settings(1'b0, 8'hFF, 16'd0);
    push_tick();

    // random phases, register settings cycling through the extremes
    rand_start = words_queued;
    for (int unsigned k = 0; words_queued - rand_start < RandWords; k++) begin
      case (k % 6)
        0:       timeout = 16'd1;
        1:       timeout = 16'd2;
        2:       timeout = 16'd7;
        3:       timeout = TimeoutReset;
        4:       timeout = 16'hFFFF;
        default: timeout = 16'($urandom_range(1, 40));
      endcase
      case (k % 3)
        0:       over = 8'h00;
        1:       over = 8'hFF;
        default: over = 8'($urandom_range(0, 255));
      endcase
      apply_settings(k % 5 == 3, over, timeout);
      phase_start = words_queued;
      while (words_queued - phase_start < PhaseWords) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          push_session();
        end else if (pick == 7) begin
          push_byte(PingByte);
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 8)) push_tick();
        end
      end
    end

    wait_drained();
    if (expected_results_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results_q.size()));

    $display("Covered %0d input words (%0d sessions) and %0d result words",
             words_sent, sessions_built, results_seen);
    $display("over %0d register settings, mismatches counted: %0d",
             settings_count, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
